FILE: rtl/core/pgb_pkg.sv
// Package for the particle grid binning core: state, status and register codes,
// the axis control group and default sizes. No dependencies.
package pgb_pkg;

  // Default grid and block sizes.
  localparam int GRID_X_DEF   = 16;
  localparam int GRID_Y_DEF   = 16;
  localparam int GRID_Z_DEF   = 16;
  localparam int CAPACITY_DEF = 8;
  localparam int GRID_DEF     = 16;

  // Payload widths.
  localparam int COORD_W = 32;
  localparam int ID_W    = 31;

  // Remainder unit: steps from the floored index to its remainder by the grid size
  // (byte fold, reciprocal multiply, multiply back and subtract).
  localparam int MOD_STEPS = 3;
  localparam int MODC_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Reset value of a scale register: width 1.0 and reciprocal 1.0.
  localparam logic [63:0] SCALE_RST = 64'h0000_0001_0001_0000;

  // Command carried on in_tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_STORED  = 2'd0,
    STATUS_OOB     = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_CLEARED = 2'd3
  } pgb_status_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_SCALE_X  = 3'd3,
    CFG_SCALE_Y  = 3'd4,
    CFG_SCALE_Z  = 3'd5,
    CFG_PERIODIC = 3'd6
  } pgb_cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUB,
    ST_MUL,
    ST_FLOOR,
    ST_MOD,
    ST_WRAP,
    ST_REMAP,
    ST_BLK,
    ST_READ,
    ST_UPDATE,
    ST_PUSH
  } pgb_state_t;

  // One step enable per stage of the axis lane.
  typedef struct packed {
    logic load;
    logic sub;
    logic mul;
    logic flr;
    logic mod_step;
    logic wrap;
    logic remap;
  } pgb_axis_ctl_t;

endpackage

FILE: rtl/core/pgb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pgb_ram #(
  parameter int              WIDTH = 8,
  parameter longint unsigned DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/pgb_axis.sv
// One axis lane of the binning core: offset, reciprocal multiply, floor,
// remainder by the grid size and periodic remap. Depends on pgb_pkg.
module pgb_axis #(
  parameter int GRID = pgb_pkg::GRID_DEF
) (
  input  logic                                        clk,
  input  pgb_pkg::pgb_axis_ctl_t                      ctl,
  input  logic [31:0]                                 pos_i,
  input  logic [31:0]                                 org_i,
  input  logic [63:0]                                 scale_i,
  input  logic                                        prd_i,
  output logic [((GRID > 1) ? $clog2(GRID) : 1)-1:0]  idx_o,
  output logic                                        oob_o,
  output logic [31:0]                                 wrapped_o,
  output logic [31:0]                                 pos_o
);

  localparam int IW = (GRID > 1) ? $clog2(GRID) : 1;
  // Remainder width: holds values below the grid size, plus the grid size itself.
  localparam int RW = $clog2(GRID) + 1;
  // Folded index: three byte-by-constant products below 2^16 each, plus a byte.
  localparam int FW = 18;
  // Reciprocal of the grid size, exact for every folded value.
  localparam int KS = FW + $clog2(GRID);
  localparam longint unsigned RECIP = ((64'd1 << KS) + 64'(GRID) - 64'd1) / 64'(GRID);
  localparam int MW = FW + 1;
  localparam int PW = FW + MW;
  // Weights of the upper index bytes, taken modulo the grid size.
  localparam int C1 = (1 << 8) % GRID;
  localparam int C2 = (1 << 16) % GRID;
  localparam int C3 = (1 << 24) % GRID;

  logic [31:0]   pos_r;
  logic          neg_r;
  logic [31:0]   mag_r;
  logic [63:0]   prod_r;
  logic [31:0]   q_r;
  logic [FW-1:0] fold_r;
  logic [FW-1:0] quo_r;
  logic [RW-1:0] rem_r;
  logic [IW-1:0] idx_r;
  logic          oob_r;
  logic [31:0]   shift_r;
  logic [31:0]   wrapped_r;

  logic [32:0]   d_pos;
  logic [32:0]   d_negd;
  logic [31:0]   q_nxt;
  logic          ineg;
  logic [FW-1:0] fold_nxt;
  logic [PW-1:0] qprod;
  logic [FW-1:0] quo_nxt;
  logic [FW-1:0] rem_full;
  logic [RW-1:0] rem_nxt;
  logic [RW-1:0] l_val;
  logic [31:0]   l32;
  logic [31:0]   shift_nxt;
  logic [31:0]   wmul;

  // Offset from the origin, both ways, so the magnitude needs only a select.
  assign d_pos  = {pos_r[31], pos_r} - {org_i[31], org_i};
  assign d_negd = {org_i[31], org_i} - {pos_r[31], pos_r};

  // Round toward minus infinity: a negative product with a fraction steps down.
  assign q_nxt = prod_r[63:32] + {31'b0, neg_r & (|prod_r[31:0])};
  assign ineg  = neg_r & (q_r != 32'd0);

  // Remainder in three registered steps while q_r holds still: fold the index bytes into a
  // small value of the same residue, divide it by a reciprocal multiply, then subtract.
  assign fold_nxt = FW'(q_r[31:24]) * FW'(C3) + FW'(q_r[23:16]) * FW'(C2)
                  + FW'(q_r[15:8]) * FW'(C1) + FW'(q_r[7:0]);
  assign qprod    = PW'(fold_r) * PW'(RECIP);
  assign quo_nxt  = FW'(qprod >> KS);
  assign rem_full = fold_r - FW'(GRID) * quo_r;
  assign rem_nxt  = rem_full[RW-1:0];

  // Wrapped index of a negative raw index is the grid size minus the remainder, or zero if that is zero.
  always_comb begin
    if (ineg && (rem_r != '0)) begin
      l_val = RW'(GRID) - rem_r;
    end else if (ineg) begin
      l_val = '0;
    end else begin
      l_val = rem_r;
    end
  end

  assign l32       = 32'(l_val);
  assign shift_nxt = ineg ? (l32 + q_r) : (l32 - q_r);
  assign wmul      = scale_i[63:32] * shift_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_r <= pos_i;
    end
    if (ctl.sub) begin
      neg_r <= d_pos[32];
      mag_r <= d_pos[32] ? d_negd[31:0] : d_pos[31:0];
    end
    if (ctl.mul) begin
      prod_r <= 64'(mag_r) * 64'(scale_i[31:0]);
    end
    if (ctl.flr) begin
      q_r   <= q_nxt;
      rem_r <= '0;
    end
    if (ctl.mod_step) begin
      fold_r <= fold_nxt;
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
    end
    if (ctl.wrap) begin
      idx_r   <= prd_i ? l_val[IW-1:0] : q_r[IW-1:0];
      oob_r   <= !prd_i && (ineg || (q_r >= 32'(GRID)));
      shift_r <= prd_i ? shift_nxt : 32'd0;
    end
    if (ctl.remap) begin
      wrapped_r <= pos_r + wmul;
    end
  end

  assign idx_o     = idx_r;
  assign oob_o     = oob_r;
  assign wrapped_o = wrapped_r;
  assign pos_o     = pos_r;

endmodule

FILE: rtl/core/particle_grid_binning_core.sv
// Top level of the particle grid binning core: configuration registers,
// sequencer, block count memory and slot store. Depends on pgb_pkg, pgb_axis, pgb_ram.
//
// Channel | Direction | Ports                                   | One beat carries
// in      | slave     | in_tvalid, in_tready, in_tdata, in_tuser | one insert or clear command
// out     | master    | out_tvalid, out_tready, out_tdata, out_tuser | one result
// cfg     | write     | cfg_we, cfg_index, cfg_wdata            | one register write
//
// An insert runs through SUB, MUL, FLOOR, WRAP, REMAP, BLK, READ, UPDATE to its result in the
// output register (no UPDATE when out of range); MOD follows FLOOR if any axis is periodic:
// the remainder unit folds, divides by a reciprocal multiply and subtracts, one step a cycle.
// The block count read-modify-write runs on the one port pair of the count memory.
// A clear command, and reset, sweep the count memory one block a cycle over all
// GRID_X*GRID_Y*GRID_Z blocks (4096 by default), during which no beat is accepted.
// A finished result waits in the output register while the next beat is taken.
module particle_grid_binning_core #(
  parameter int GRID_X         = pgb_pkg::GRID_X_DEF,
  parameter int GRID_Y         = pgb_pkg::GRID_Y_DEF,
  parameter int GRID_Z         = pgb_pkg::GRID_Z_DEF,
  parameter int BLOCK_CAPACITY = pgb_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // Input channel.
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // particle_id[30:0], pos_x[62:31], pos_y[94:63],
                                    // pos_z[126:95], zero pad[127]
  input  logic          in_tuser,   // command[0]
  // Result channel.
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // block_index[11:0], slot[14:12], wrapped_x[46:15],
                                    // wrapped_y[78:47], wrapped_z[110:79], zero pad[111]
  output logic [1:0]    out_tuser,  // status[1:0]
  // Configuration port.
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_wdata
);

  localparam int XW      = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YW      = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int ZW      = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int NBLOCKS = GRID_X * GRID_Y * GRID_Z;
  localparam int BAW     = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
  localparam int NYZ     = GRID_Y * GRID_Z;
  localparam int JKW     = (NYZ > 1) ? $clog2(NYZ) : 1;
  localparam int FILL_W  = $clog2(BLOCK_CAPACITY + 1);
  localparam longint unsigned NSLOTS = longint'(NBLOCKS) * longint'(BLOCK_CAPACITY);
  localparam int SAW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int STORE_W = pgb_pkg::ID_W + 3 * pgb_pkg::COORD_W;

  // Configuration registers.
  logic [31:0] origin_x_r, origin_y_r, origin_z_r;
  logic [63:0] scale_x_r, scale_y_r, scale_z_r;
  logic [2:0]  periodic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      scale_x_r  <= pgb_pkg::SCALE_RST;
      scale_y_r  <= pgb_pkg::SCALE_RST;
      scale_z_r  <= pgb_pkg::SCALE_RST;
      periodic_r <= '0;
    end else if (cfg_we) begin
      unique case (pgb_pkg::pgb_cfg_t'(cfg_index))
        pgb_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_wdata[31:0];
        pgb_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_wdata[31:0];
        pgb_pkg::CFG_ORIGIN_Z: origin_z_r <= cfg_wdata[31:0];
        pgb_pkg::CFG_SCALE_X:  scale_x_r  <= cfg_wdata;
        pgb_pkg::CFG_SCALE_Y:  scale_y_r  <= cfg_wdata;
        pgb_pkg::CFG_SCALE_Z:  scale_z_r  <= cfg_wdata;
        pgb_pkg::CFG_PERIODIC: periodic_r <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state.
  pgb_pkg::pgb_state_t  state_r, state_nxt;
  logic [BAW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                 clr_cmd_r, clr_cmd_nxt;
  logic [pgb_pkg::MODC_W-1:0] mod_cnt_r, mod_cnt_nxt;
  pgb_pkg::pgb_status_t res_status_r, res_status_nxt;
  logic [2:0]           res_slot_r, res_slot_nxt;

  // Item payload kept in the top level.
  logic [pgb_pkg::ID_W-1:0] id_r;
  logic [JKW-1:0]           jk_r, jk_nxt;
  logic [BAW-1:0]           blk_r, blk_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [11:0]          out_blk_r, out_blk_nxt;
  logic [2:0]           out_slot_r, out_slot_nxt;
  logic [31:0]          out_wx_r, out_wx_nxt;
  logic [31:0]          out_wy_r, out_wy_nxt;
  logic [31:0]          out_wz_r, out_wz_nxt;
  logic                 out_load;

  // Axis lanes.
  pgb_pkg::pgb_axis_ctl_t ctl;
  logic [XW-1:0] idx_x;
  logic [YW-1:0] idx_y;
  logic [ZW-1:0] idx_z;
  logic          oob_x, oob_y, oob_z, oob_any;
  logic [31:0]   wx, wy, wz;
  logic [31:0]   px, py, pz;

  pgb_axis #(.GRID(GRID_X)) u_axis_x (
    .clk       (clk),
    .ctl       (ctl),
    .pos_i     (in_tdata[62:31]),
    .org_i     (origin_x_r),
    .scale_i   (scale_x_r),
    .prd_i     (periodic_r[0]),
    .idx_o     (idx_x),
    .oob_o     (oob_x),
    .wrapped_o (wx),
    .pos_o     (px)
  );

  pgb_axis #(.GRID(GRID_Y)) u_axis_y (
    .clk       (clk),
    .ctl       (ctl),
    .pos_i     (in_tdata[94:63]),
    .org_i     (origin_y_r),
    .scale_i   (scale_y_r),
    .prd_i     (periodic_r[1]),
    .idx_o     (idx_y),
    .oob_o     (oob_y),
    .wrapped_o (wy),
    .pos_o     (py)
  );

  pgb_axis #(.GRID(GRID_Z)) u_axis_z (
    .clk       (clk),
    .ctl       (ctl),
    .pos_i     (in_tdata[126:95]),
    .org_i     (origin_z_r),
    .scale_i   (scale_z_r),
    .prd_i     (periodic_r[2]),
    .idx_o     (idx_z),
    .oob_o     (oob_z),
    .wrapped_o (wz),
    .pos_o     (pz)
  );

  assign oob_any = oob_x | oob_y | oob_z;

  // Linear block index, built in two registered steps.
  assign jk_nxt  = JKW'(idx_y) + JKW'(GRID_Y) * JKW'(idx_z);
  assign blk_nxt = BAW'(idx_x) + BAW'(GRID_X) * BAW'(jk_r);

  // Block count memory.
  logic              fill_we, fill_re;
  logic [BAW-1:0]    fill_waddr;
  logic [FILL_W-1:0] fill_wdata, fill_rd;
  logic              fill_full;

  pgb_ram #(.WIDTH(FILL_W), .DEPTH(NBLOCKS)) u_fill_ram (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_waddr),
    .wr_data (fill_wdata),
    .rd_en   (fill_re),
    .rd_addr (blk_r),
    .rd_data (fill_rd)
  );

  assign fill_full = (fill_rd >= FILL_W'(BLOCK_CAPACITY));

  // Slot store: one entry per slot of every block, written only.
  logic               store_we;
  logic [SAW-1:0]     store_addr;
  logic [STORE_W-1:0] store_data;

  assign store_addr = SAW'(blk_r) * SAW'(BLOCK_CAPACITY) + SAW'(fill_rd);
  assign store_data = {wz, wy, wx, id_r};

  pgb_ram #(.WIDTH(STORE_W), .DEPTH(NSLOTS)) u_store_ram (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (store_addr),
    .wr_data (store_data),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  // Next state and step enables.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_cmd_nxt    = clr_cmd_r;
    mod_cnt_nxt    = mod_cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    ctl            = '0;
    fill_we        = 1'b0;
    fill_re        = 1'b0;
    fill_waddr     = blk_r;
    fill_wdata     = '0;
    store_we       = 1'b0;
    out_load       = 1'b0;
    in_tready      = 1'b0;
    unique case (state_r)
      pgb_pkg::ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_addr_r;
        if (clr_addr_r == BAW'(NBLOCKS - 1)) begin
          clr_cmd_nxt = 1'b0;
          if (clr_cmd_r) begin
            res_status_nxt = pgb_pkg::STATUS_CLEARED;
            res_slot_nxt   = '0;
            state_nxt      = pgb_pkg::ST_PUSH;
          end else begin
            state_nxt = pgb_pkg::ST_IDLE;
          end
        end else begin
          clr_addr_nxt = clr_addr_r + BAW'(1);
        end
      end
      pgb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == pgb_pkg::CMD_CLEAR) begin
            clr_addr_nxt = '0;
            clr_cmd_nxt  = 1'b1;
            state_nxt    = pgb_pkg::ST_CLEAR;
          end else begin
            ctl.load  = 1'b1;
            state_nxt = pgb_pkg::ST_SUB;
          end
        end
      end
      pgb_pkg::ST_SUB: begin
        ctl.sub   = 1'b1;
        state_nxt = pgb_pkg::ST_MUL;
      end
      pgb_pkg::ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = pgb_pkg::ST_FLOOR;
      end
      pgb_pkg::ST_FLOOR: begin
        ctl.flr     = 1'b1;
        mod_cnt_nxt = '0;
        state_nxt   = (|periodic_r) ? pgb_pkg::ST_MOD : pgb_pkg::ST_WRAP;
      end
      pgb_pkg::ST_MOD: begin
        ctl.mod_step = 1'b1;
        if (mod_cnt_r == pgb_pkg::MODC_W'(pgb_pkg::MOD_STEPS - 1)) begin
          state_nxt = pgb_pkg::ST_WRAP;
        end else begin
          mod_cnt_nxt = mod_cnt_r + pgb_pkg::MODC_W'(1);
        end
      end
      pgb_pkg::ST_WRAP: begin
        ctl.wrap  = 1'b1;
        state_nxt = pgb_pkg::ST_REMAP;
      end
      pgb_pkg::ST_REMAP: begin
        ctl.remap = 1'b1;
        state_nxt = pgb_pkg::ST_BLK;
      end
      pgb_pkg::ST_BLK: begin
        state_nxt = pgb_pkg::ST_READ;
      end
      pgb_pkg::ST_READ: begin
        if (oob_any) begin
          res_status_nxt = pgb_pkg::STATUS_OOB;
          res_slot_nxt   = '0;
          state_nxt      = pgb_pkg::ST_PUSH;
        end else begin
          fill_re   = 1'b1;
          state_nxt = pgb_pkg::ST_UPDATE;
        end
      end
      pgb_pkg::ST_UPDATE: begin
        if (fill_full) begin
          res_status_nxt = pgb_pkg::STATUS_FULL;
          res_slot_nxt   = '0;
        end else begin
          fill_we        = 1'b1;
          fill_wdata     = fill_rd + FILL_W'(1);
          store_we       = 1'b1;
          res_status_nxt = pgb_pkg::STATUS_STORED;
          res_slot_nxt   = 3'(fill_rd);
        end
        state_nxt = pgb_pkg::ST_PUSH;
      end
      pgb_pkg::ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = pgb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pgb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pgb_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      clr_cmd_r    <= 1'b0;
      mod_cnt_r    <= '0;
      res_status_r <= pgb_pkg::STATUS_STORED;
      res_slot_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_cmd_r    <= clr_cmd_nxt;
      mod_cnt_r    <= mod_cnt_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r <= in_tdata[30:0];
    end
    if (state_r == pgb_pkg::ST_REMAP) begin
      jk_r <= jk_nxt;
    end
    if (state_r == pgb_pkg::ST_BLK) begin
      blk_r <= blk_nxt;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_blk_r    <= out_blk_nxt;
      out_slot_r   <= out_slot_nxt;
      out_wx_r     <= out_wx_nxt;
      out_wy_r     <= out_wy_nxt;
      out_wz_r     <= out_wz_nxt;
    end
  end

  // Result fields. A particle out of range reports its coordinates untouched on every axis.
  always_comb begin
    out_status_nxt = res_status_r;
    out_slot_nxt   = res_slot_r;
    unique case (res_status_r)
      pgb_pkg::STATUS_STORED, pgb_pkg::STATUS_FULL: begin
        out_blk_nxt = 12'(blk_r);
        out_wx_nxt  = wx;
        out_wy_nxt  = wy;
        out_wz_nxt  = wz;
      end
      pgb_pkg::STATUS_OOB: begin
        out_blk_nxt = '0;
        out_wx_nxt  = px;
        out_wy_nxt  = py;
        out_wz_nxt  = pz;
      end
      default: begin
        out_blk_nxt = '0;
        out_wx_nxt  = '0;
        out_wy_nxt  = '0;
        out_wz_nxt  = '0;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_wz_r, out_wy_r, out_wx_r, out_slot_r, out_blk_r};

`ifndef SYNTHESIS
  // The output register is only reloaded once its previous beat has gone.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("output register reloaded while holding a beat");

  // A block count written back by an insert never passes the capacity.
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_we && (state_r == pgb_pkg::ST_UPDATE)) |-> (fill_wdata <= FILL_W'(BLOCK_CAPACITY)))
    else $error("block count written beyond capacity");

  // An accepted insert beat starts the axis lanes in the next cycle.
  a_insert_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == pgb_pkg::CMD_INSERT))
      |=> (state_r == pgb_pkg::ST_SUB))
    else $error("insert beat accepted without starting the lanes");
`endif

endmodule
